@@ rtl/lr_pkg.sv @@
package lr_pkg;

	// Screen size and register reset
	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 64;
	localparam int MAJOR_MAX     = (SCREEN_WIDTH > SCREEN_HEIGHT) ?
	                               SCREEN_WIDTH - 1 : SCREEN_HEIGHT - 1;
	localparam logic [7:0] ORIGIN_RESET = 8'(128 / 2);

	// Field widths
	localparam int IN_W    = 12;
	localparam int COORD_W = IN_W + 1;   // input plus offset
	localparam int DIFF_W  = COORD_W + 1;
	localparam int ERR_W   = 16;
	localparam int PIX_W   = 6;
	localparam int COLOR_W = 16;
	localparam int OFF_W   = 8;

	// Command queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [ERR_W-1:0]   err_t;

	localparam coord_t X_LIMIT   = coord_t'(SCREEN_WIDTH);
	localparam coord_t Y_LIMIT   = coord_t'(SCREEN_HEIGHT);
	localparam coord_t MAJOR_END = coord_t'(MAJOR_MAX);

	// Classified line, ready for stepping
	typedef struct packed {
		logic                 steep;
		coord_t               major_start;
		coord_t               major_end;
		coord_t               minor_start;
		logic [COORD_W-1:0]   dx;
		logic [COORD_W:0]     step2;
		logic                 ydown;
		logic [COLOR_W-1:0]   color;
	} setup_t;

	// One result item
	typedef struct packed {
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [COLOR_W-1:0] color;
		logic               valid;
		logic               last;
	} pix_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_LAST
	} bk_state_t;

endpackage

@@ rtl/lr_front.sv @@
module lr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lr_pkg::OFF_W-1:0]   origin_offset,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [63:0]                s_axis_tdata,
	output logic                       setup_valid,
	input  logic                       setup_ready,
	output lr_pkg::setup_t             setup
);
	import lr_pkg::*;

	logic en1, en2, en3;
	logic valid_s1, valid_s2, valid_s3;

	coord_t ax_s1, ay_s1, bx_s1, by_s1;
	logic [COLOR_W-1:0] color_s1, color_s2;

	coord_t ma_s2, na_s2, mb_s2, nb_s2;
	logic steep_s2;

	setup_t setup_s3;

	// Stage enables: a stage loads when empty or when its item moves on
	assign en3 = !valid_s3 || setup_ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign s_axis_tready = en1;

	// Stage 1: add origin offset
	coord_t ax_c, ay_c, bx_c, by_c;
	logic [COORD_W-1:0] off_ext;
	assign off_ext = {{(COORD_W-OFF_W){1'b0}}, origin_offset};
	assign ax_c = coord_t'({s_axis_tdata[11], s_axis_tdata[11:0]} + off_ext);
	assign ay_c = coord_t'({s_axis_tdata[23], s_axis_tdata[23:12]} + off_ext);
	assign bx_c = coord_t'({s_axis_tdata[35], s_axis_tdata[35:24]} + off_ext);
	assign by_c = coord_t'({s_axis_tdata[47], s_axis_tdata[47:36]} + off_ext);

	// Stage 2: steep test and axis exchange
	diff_t ddx, ddy, adx, ady;
	logic  steep_c;
	always_comb begin
		ddx = diff_t'({ax_s1[COORD_W-1], ax_s1}) - diff_t'({bx_s1[COORD_W-1], bx_s1});
		ddy = diff_t'({ay_s1[COORD_W-1], ay_s1}) - diff_t'({by_s1[COORD_W-1], by_s1});
		adx = ddx[DIFF_W-1] ? -ddx : ddx;
		ady = ddy[DIFF_W-1] ? -ddy : ddy;
		steep_c = $unsigned(adx) < $unsigned(ady);
	end

	// Stage 3: order by major axis, deltas and step direction
	logic  swap_c;
	coord_t m0, m1, n0, n1;
	diff_t dmaj, dmin, amin;
	always_comb begin
		swap_c = ma_s2 > mb_s2;
		m0 = swap_c ? mb_s2 : ma_s2;
		m1 = swap_c ? ma_s2 : mb_s2;
		n0 = swap_c ? nb_s2 : na_s2;
		n1 = swap_c ? na_s2 : nb_s2;
		dmaj = diff_t'({m1[COORD_W-1], m1}) - diff_t'({m0[COORD_W-1], m0});
		dmin = diff_t'({n1[COORD_W-1], n1}) - diff_t'({n0[COORD_W-1], n0});
		amin = dmin[DIFF_W-1] ? -dmin : dmin;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= s_axis_tvalid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1    <= ax_c;
			ay_s1    <= ay_c;
			bx_s1    <= bx_c;
			by_s1    <= by_c;
			color_s1 <= s_axis_tdata[63:48];
		end
		if (en2) begin
			steep_s2 <= steep_c;
			ma_s2    <= steep_c ? ay_s1 : ax_s1;
			na_s2    <= steep_c ? ax_s1 : ay_s1;
			mb_s2    <= steep_c ? by_s1 : bx_s1;
			nb_s2    <= steep_c ? bx_s1 : by_s1;
			color_s2 <= color_s1;
		end
		if (en3) begin
			setup_s3.steep       <= steep_s2;
			setup_s3.major_start <= m0;
			setup_s3.major_end   <= m1;
			setup_s3.minor_start <= n0;
			setup_s3.dx          <= dmaj[COORD_W-1:0];
			setup_s3.step2       <= {amin[COORD_W-1:0], 1'b0};
			setup_s3.ydown       <= !(n1 > n0);
			setup_s3.color       <= color_s2;
		end
	end

	assign setup_valid = valid_s3;
	assign setup       = setup_s3;

endmodule

@@ rtl/lr_fifo.sv @@
module lr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  lr_pkg::setup_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output lr_pkg::setup_t rd_data
);
	import lr_pkg::*;

	setup_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic push, pop;

	assign wr_ready = count_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

@@ rtl/lr_back.sv @@
module lr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           setup_valid,
	output logic           setup_ready,
	input  lr_pkg::setup_t setup,
	output logic           out_valid,
	input  logic           out_ready,
	output lr_pkg::pix_t   out_pix
);
	import lr_pkg::*;

	bk_state_t state_q, state_d;

	coord_t major_q, end_q, minor_q;
	err_t   err_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W:0]   step2_q;
	logic steep_q, ydown_q;
	logic [COLOR_W-1:0] color_q;

	logic pend_v_q;
	logic [PIX_W-1:0] pend_x_q, pend_y_q;

	logic out_v_q;
	pix_t out_q;

	logic out_free, load, step, emit_pend, emit_last;

	// Current pixel and its visibility
	coord_t cur_x, cur_y;
	logic   vis, at_end;
	always_comb begin
		cur_x  = steep_q ? minor_q : major_q;
		cur_y  = steep_q ? major_q : minor_q;
		vis    = !cur_x[COORD_W-1] && (cur_x < X_LIMIT) &&
		         !cur_y[COORD_W-1] && (cur_y < Y_LIMIT);
		at_end = (major_q == end_q) || (major_q >= MAJOR_END);
	end

	// Error term update
	err_t err_add, err_next;
	logic minor_move;
	always_comb begin
		err_add    = err_q + err_t'({1'b0, step2_q});
		minor_move = err_add > err_t'({1'b0, dx_q});
		err_next   = minor_move ? err_add - err_t'({1'b0, dx_q, 1'b0}) : err_add;
	end

	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else         state_q <= state_d;
	end

	// Sequencer: pull a line, step it, close it with the marked result
	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		step      = 1'b0;
		emit_pend = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (setup_valid) begin
					load    = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				// a new visible pixel pushes out the held one
				if (!(vis && pend_v_q && !out_free)) begin
					step      = 1'b1;
					emit_pend = vis && pend_v_q;
					if (at_end) state_d = BK_LAST;
				end
			end
			BK_LAST: begin
				if (out_free) begin
					emit_last = 1'b1;
					load      = setup_valid;
					state_d   = setup_valid ? BK_RUN : BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign setup_ready = load;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load)          pend_v_q <= 1'b0;
			else if (step && vis) pend_v_q <= 1'b1;
			if (emit_pend || emit_last) out_v_q <= 1'b1;
			else if (out_ready)         out_v_q <= 1'b0;
		end
	end

	// Stepping datapath
	always_ff @(posedge clk) begin
		if (load) begin
			major_q <= setup.major_start;
			end_q   <= setup.major_end;
			minor_q <= setup.minor_start;
			err_q   <= '0;
			dx_q    <= setup.dx;
			step2_q <= setup.step2;
			steep_q <= setup.steep;
			ydown_q <= setup.ydown;
			color_q <= setup.color;
		end else if (step) begin
			major_q <= major_q + coord_t'(1);
			err_q   <= err_next;
			if (minor_move) minor_q <= ydown_q ? minor_q - coord_t'(1) : minor_q + coord_t'(1);
			if (vis) begin
				pend_x_q <= cur_x[PIX_W-1:0];
				pend_y_q <= cur_y[PIX_W-1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit_pend) begin
			out_q <= '{x: pend_x_q, y: pend_y_q, color: color_q, valid: 1'b1, last: 1'b0};
		end else if (emit_last) begin
			if (pend_v_q) begin
				out_q <= '{x: pend_x_q, y: pend_y_q, color: color_q,
				           valid: 1'b1, last: 1'b1};
			end else begin
				out_q <= '{x: '0, y: '0, color: '0, valid: 1'b0, last: 1'b1};
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_pix   = out_q;

endmodule

@@ rtl/line_rasterizer.sv @@
// Line rasterizer: draws one line per input item with integer Bresenham steps.
// Input stream (s_axis): one line command per item, endpoints in two's complement.
// Output stream (m_axis): one item per visible pixel in stepping order; tlast
// marks the final item of a command. A line with no visible pixel yields one
// item with tuser = 0, tlast = 1 and zero data.
// cfg_wen/cfg_wdata write the origin offset added to all coordinates; write it
// only while no command is in flight. Reset sets it to 64.
// A command passes a three-stage setup pipeline and a two-entry queue,
// then the stepping unit visits one major-axis position per cycle while the
// output is not stalled, from the lower endpoint up to the upper one or the
// last screen position (63), whichever comes first, and then closes the line.
// Setup of the next command overlaps stepping of the current one.
// A stalled output holds the stepping unit once the next pixel is found; the
// setup pipeline and queue keep taking commands until full. Reset clears the
// pipeline, the queue and the output register.
module line_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,     // origin_offset
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // start_x, start_y, end_x, end_y, line_color
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // pixel_x, pixel_y, pixel_color, zero pad
	output logic        m_axis_tuser,  // pixel_valid
	output logic        m_axis_tlast   // last
);
	import lr_pkg::*;

	logic [OFF_W-1:0] origin_offset_q;

	logic   fr_valid, fr_ready, q_valid, q_ready;
	setup_t fr_setup, q_setup;
	pix_t   pix;

	// Origin offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)      origin_offset_q <= ORIGIN_RESET;
		else if (cfg_wen) origin_offset_q <= cfg_wdata;
	end

	lr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.origin_offset (origin_offset_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.setup_valid   (fr_valid),
		.setup_ready   (fr_ready),
		.setup         (fr_setup)
	);

	lr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_setup),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_setup)
	);

	lr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.setup_valid (q_valid),
		.setup_ready (q_ready),
		.setup       (q_setup),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_pix     (pix)
	);

	assign m_axis_tdata = {4'b0, pix.color, pix.y, pix.x};
	assign m_axis_tuser = pix.valid;
	assign m_axis_tlast = pix.last;

endmodule

@@ bench/line_rasterizer_tb.sv @@
module line_rasterizer_tb;
	import lr_pkg::*;

	// One line command, laid out as it travels on s_axis_tdata (sx in the low bits)
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic signed [11:0] ey;
		logic signed [11:0] ex;
		logic signed [11:0] sy;
		logic signed [11:0] sx;
	} line_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	line_cmd_t  lines_waiting[$];
	line_cmd_t  line_cur;
	pix_t       pixels_due[$];
	logic [7:0] origin_model = ORIGIN_RESET;
	int         idle_pct = 32;
	int         lines_queued = 0;
	int         lines_taken = 0;
	int         errors = 0;

	line_rasterizer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	// Bresenham walk of one command; pushes every visible pixel, last one marked, or one empty marked item
	function automatic void trace_line(line_cmd_t c);
		int   ax, ay, bx, by, t, dx, step2, err, minor, ystep, px, py;
		bit   steep, found;
		pix_t held;
		ax = int'($signed(c.sx)) + int'(origin_model);
		ay = int'($signed(c.sy)) + int'(origin_model);
		bx = int'($signed(c.ex)) + int'(origin_model);
		by = int'($signed(c.ey)) + int'(origin_model);
		steep = mag(ax - bx) < mag(ay - by);
		if (steep) begin
			t = ax; ax = ay; ay = t;
			t = bx; bx = by; by = t;
		end
		if (ax > bx) begin
			t = ax; ax = bx; bx = t;
			t = ay; ay = by; by = t;
		end
		dx = bx - ax;
		step2 = 2 * mag(by - ay);
		ystep = (by > ay) ? 1 : -1;
		err = 0;
		minor = ay;
		found = 1'b0;
		held = '0;
		for (int major = ax; major <= bx; major++) begin
			px = steep ? minor : major;
			py = steep ? major : minor;
			if (px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT) begin
				// hold one back so the final pixel can carry last
				if (found)
					pixels_due.push_back(held);
				held.x = px[PIX_W-1:0];
				held.y = py[PIX_W-1:0];
				held.color = c.color;
				held.valid = 1'b1;
				held.last = 1'b0;
				found = 1'b1;
			end
			err += step2;
			if (err > dx) begin
				minor += ystep;
				err -= 2 * dx;
			end
		end
		// nothing visible: held is still all zero, i.e. the empty item
		held.last = 1'b1;
		pixels_due.push_back(held);
	endfunction

	function automatic line_cmd_t raw_line(int x0, int y0, int x1, int y1,
	                                       logic [COLOR_W-1:0] col);
		line_cmd_t c;
		c.sx = 12'(x0);
		c.sy = 12'(y0);
		c.ex = 12'(x1);
		c.ey = 12'(y1);
		c.color = col;
		return c;
	endfunction

	// Endpoints given in screen coordinates under the current origin
	function automatic line_cmd_t line_at(int x0, int y0, int x1, int y1,
	                                      logic [COLOR_W-1:0] col);
		int off;
		off = int'(origin_model);
		return raw_line(x0 - off, y0 - off, x1 - off, y1 - off, col);
	endfunction

	function automatic line_cmd_t random_line();
		int                 kind, x0, y0, x1, y1, len;
		logic [COLOR_W-1:0] col;
		line_cmd_t          c;
		kind = int'($urandom_range(99));
		col = 16'($urandom);
		x0 = int'($urandom_range(111)) - 24;
		y0 = int'($urandom_range(111)) - 24;
		x1 = int'($urandom_range(111)) - 24;
		y1 = int'($urandom_range(111)) - 24;
		if (kind < 8) begin
			// anywhere in the 12-bit range; can be long off-screen walks
			c = {16'($urandom), 16'($urandom), 32'($urandom)};
			return c;
		end else if (kind < 20) begin
			x1 = x0 + int'($urandom_range(16)) - 8;
			y1 = y0 + int'($urandom_range(16)) - 8;
		end else if (kind < 32) begin
			len = int'($urandom_range(80));
			case ($urandom_range(3))
				0: begin
					x1 = x0;
					y1 = y0;
				end
				1: y1 = y0;
				2: x1 = x0;
				default: begin
					x1 = $urandom_range(1) ? x0 + len : x0 - len;
					y1 = $urandom_range(1) ? y0 + len : y0 - len;
				end
			endcase
		end
		return line_at(x0, y0, x1, y1, col);
	endfunction

	task automatic queue_line(input line_cmd_t c);
		lines_waiting.push_back(c);
		lines_queued++;
	endtask

	task automatic queue_random(input int count);
		for (int k = 0; k < count; k++)
			queue_line(random_line());
	endtask

	// Hold until every command is taken and every pixel has come back
	task automatic settle();
		while (lines_taken != lines_queued || pixels_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_origin(input logic [7:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		origin_model = v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Command driver: present queued lines, predict each accepted one
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				trace_line(line_cur);
				lines_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (lines_waiting.size() > 0 && int'($urandom_range(99)) >= idle_pct) begin
					line_cur = lines_waiting.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= line_cur;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Pixel monitor: compare each accepted item with the oldest prediction
	always @(posedge clk) begin
		pix_t seen, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.x = m_axis_tdata[5:0];
				seen.y = m_axis_tdata[11:6];
				seen.color = m_axis_tdata[27:12];
				seen.valid = m_axis_tuser;
				seen.last = m_axis_tlast;
				if (pixels_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected pixel: x=%0d y=%0d color=%h valid=%b last=%b",
						         seen.x, seen.y, seen.color, seen.valid, seen.last);
					errors++;
				end else begin
					want = pixels_due.pop_front();
					if (seen !== want || m_axis_tdata[31:28] !== 4'b0) begin
						if (errors < 10)
							$display("pixel mismatch: exp x=%0d y=%0d color=%h valid=%b last=%b %s",
							         want.x, want.y, want.color, want.valid, want.last,
							         "pad=0");
						if (errors < 10)
							$display("                got x=%0d y=%0d color=%h valid=%b last=%b pad=%h",
							         seen.x, seen.y, seen.color, seen.valid, seen.last,
							         m_axis_tdata[31:28]);
						errors++;
					end
				end
			end
			m_axis_tready <= (int'($urandom_range(99)) >= idle_pct);
		end
	end

	// Stimulus: phases at several origins, drained before each register write
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset origin: points, axis lines, diagonals, clipping, field extremes
		queue_line(line_at(10, 10, 10, 10, 16'h1234));
		queue_line(line_at(0, 0, 0, 0, 16'hFFFF));
		queue_line(line_at(63, 63, 63, 63, 16'h0000));
		queue_line(line_at(0, 5, 63, 5, 16'hA5A5));
		queue_line(line_at(63, 7, 0, 7, 16'h5A5A));
		queue_line(line_at(3, 0, 3, 63, 16'h00FF));
		queue_line(line_at(9, 63, 9, 0, 16'hFF00));
		queue_line(line_at(0, 0, 63, 63, 16'h0F0F));
		queue_line(line_at(63, 0, 0, 63, 16'hF0F0));
		queue_line(line_at(0, 0, 63, 20, 16'h3333));
		queue_line(line_at(5, 60, 20, 2, 16'hCCCC));
		queue_line(line_at(60, 10, 2, 30, 16'h6666));
		queue_line(line_at(0, 0, 1, 63, 16'h9999));
		queue_line(line_at(-30, 10, 100, 40, 16'h1111));
		queue_line(line_at(-10, -10, 80, 90, 16'h2222));
		// entirely off screen, including just past the left, right and bottom edges
		queue_line(line_at(-50, -50, -10, -20, 16'h4444));
		queue_line(line_at(100, 0, 200, 10, 16'h7777));
		queue_line(line_at(64, 0, 64, 63, 16'h8888));
		queue_line(line_at(0, 64, 63, 64, 16'hBBBB));
		queue_line(line_at(-1, 0, -1, 63, 16'hDDDD));
		// raw coordinate extremes
		queue_line(raw_line(-2048, -2048, 2047, 2047, 16'hFFFF));
		queue_line(raw_line(2047, -2048, -2048, 2047, 16'h0000));
		queue_line(raw_line(-2048, -2048, -2048, -2048, 16'hEEEE));
		queue_line(raw_line(2047, 2047, 2047, 2047, 16'h1357));
		queue_random(80);
		settle();

		set_origin(8'd0);
		queue_random(80);
		settle();

		// no idling on either side for this whole phase
		set_origin(8'd255);
		idle_pct = 0;
		queue_random(80);
		settle();
		idle_pct = 32;

		set_origin(8'($urandom_range(1, 254)));
		queue_random(80);
		settle();

		set_origin(ORIGIN_RESET);
		queue_random(60);
		settle();

		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#(8 * 3000000);
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lr_pkg.sv
rtl/lr_front.sv
rtl/lr_fifo.sv
rtl/lr_back.sv
rtl/line_rasterizer.sv
bench/line_rasterizer_tb.sv
